/* design/adsr_env_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared constants, opcode codes, store row layout and control structs.
// ----------------------------------------------------------------------------
package adsr_env_pkg;

   localparam int NUM_OPERATORS   = 36;
   localparam int LEVEL_BITS      = 32;
   localparam int OP_ADDR_BITS    = (NUM_OPERATORS > 1) ? $clog2(NUM_OPERATORS) : 1;
   localparam int OP_IDX_BITS     = 6;
   localparam int SHIFT_BITS      = 5;
   localparam int RATE_BITS       = 3 * SHIFT_BITS;
   localparam int SUSTAIN_BITS    = 32;
   localparam int ATTACK_END_BITS = 8;

   // request tdata layout, lowest bits first
   localparam int REQ_FIELD_BITS  = OP_IDX_BITS + RATE_BITS + SUSTAIN_BITS;
   localparam int REQ_TDATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS  = 32;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_KEY_ON  = 2'd1,
      OP_KEY_OFF = 2'd2,
      OP_LOAD    = 2'd3
   } opcode_type;

   // one operator row of the envelope store
   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [SHIFT_BITS-1:0] shift;
      logic                  attack;
      logic [LEVEL_BITS-1:0] bias;
      logic [RATE_BITS-1:0]  rate;    // release, decay, attack from msb down
      logic [LEVEL_BITS-1:0] sustain;
   } entry_type;

   typedef struct packed {
      logic capture;   // request beat taken, store read issued
      logic commit;    // row update and result load
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free; // output register empty or draining this cycle
   } dp_status_type;

endpackage

/* design/adsr_env_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope controller
// Two-state sequencer: take a beat and read the store, then update and emit.
// ----------------------------------------------------------------------------
module adsr_env_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  adsr_env_pkg::dp_status_type status,
   output adsr_env_pkg::ctrl_cmd_type  cmd
);
   import adsr_env_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the beat
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/adsr_env_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope datapath
// Operator store with valid bits, envelope update logic and result register.
// ----------------------------------------------------------------------------
module adsr_env_dp (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [adsr_env_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   input  logic [1:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [adsr_env_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   output logic                                       rsp_tuser,
   input  adsr_env_pkg::ctrl_cmd_type                 cmd,
   output adsr_env_pkg::dp_status_type                status
);
   import adsr_env_pkg::*;

   // request field unpack
   logic [OP_IDX_BITS-1:0]  req_idx;
   logic [RATE_BITS-1:0]    req_rate;
   logic [SUSTAIN_BITS-1:0] req_sustain;
   logic                    req_in_range;

   assign req_idx      = req_tdata[OP_IDX_BITS-1:0];
   assign req_rate     = req_tdata[OP_IDX_BITS +: RATE_BITS];
   assign req_sustain  = req_tdata[OP_IDX_BITS + RATE_BITS +: SUSTAIN_BITS];
   assign req_in_range = ((OP_IDX_BITS + 1)'(req_idx) < (OP_IDX_BITS + 1)'(NUM_OPERATORS));

   // captured item
   opcode_type              op_ff;
   logic [OP_ADDR_BITS-1:0] addr_ff;
   logic                    in_range_ff;
   logic [RATE_BITS-1:0]    rate_ff;
   logic [LEVEL_BITS-1:0]   sustain_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= opcode_type'(req_tuser);
         addr_ff     <= req_idx[OP_ADDR_BITS-1:0];
         in_range_ff <= req_in_range;
         rate_ff     <= req_rate;
         sustain_ff  <= req_sustain[LEVEL_BITS-1:0];
      end
   end

   // operator store, registered read
   entry_type                  row_mem [NUM_OPERATORS];
   logic [NUM_OPERATORS-1:0]   vld_ff;
   entry_type                  rd_row_ff;
   logic                       rd_vld_ff;
   entry_type                  wr_row;
   logic                       wr_en;

   always_ff @(posedge clock) begin
      if (cmd.capture && req_in_range) begin
         rd_row_ff <= row_mem[req_idx[OP_ADDR_BITS-1:0]];
      end
      if (wr_en) begin
         row_mem[addr_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            rd_vld_ff <= req_in_range && vld_ff[req_idx[OP_ADDR_BITS-1:0]];
         end
         if (wr_en) begin
            vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // envelope update
   entry_type             cur;
   logic [LEVEL_BITS-1:0] decayed;
   logic [LEVEL_BITS-1:0] summed;
   logic [LEVEL_BITS-1:0] result;

   assign cur     = rd_vld_ff ? rd_row_ff : '0;
   assign decayed = cur.level - (cur.level >> cur.shift);
   assign summed  = cur.level + cur.bias;
   assign wr_en   = cmd.commit && in_range_ff;

   always_comb begin
      wr_row = cur;
      result = '0;
      unique case (op_ff)
         OP_TICK: begin
            wr_row.level = decayed;
            if (cur.attack) begin
               result = ~cur.level;
               // attack ends once the inverted level drops under 256
               if (decayed[LEVEL_BITS-1:ATTACK_END_BITS] == '0) begin
                  wr_row.attack = 1'b0;
                  wr_row.bias   = cur.sustain;
                  wr_row.level  = ~cur.sustain;
                  wr_row.shift  = cur.rate[SHIFT_BITS +: SHIFT_BITS];
               end
            end else begin
               result = summed;
            end
         end
         OP_KEY_ON: begin
            if (!cur.attack) begin
               wr_row.attack = 1'b1;
               wr_row.level  = ~summed;
               wr_row.shift  = cur.rate[SHIFT_BITS-1:0];
            end
         end
         OP_KEY_OFF: begin
            if (cur.attack) begin
               wr_row.level  = ~cur.level;
               wr_row.attack = 1'b0;
            end else begin
               wr_row.level = summed;
               wr_row.bias  = '0;
            end
            wr_row.shift = cur.rate[2*SHIFT_BITS +: SHIFT_BITS];
         end
         OP_LOAD: begin
            wr_row.rate    = rate_ff;
            wr_row.sustain = sustain_ff;
         end
         default: begin
            wr_row = cur;
         end
      endcase
   end

   // result register
   logic                      rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;
   logic                      rsp_attack_ff;

   assign status.slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff   <= in_range_ff ? RSP_TDATA_BITS'(result) : '0;
         rsp_attack_ff <= in_range_ff && wr_row.attack;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_attack_ff;

endmodule

/* design/adsr_envelope_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Per-operator envelope store with exponential shift decay and key control.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser opcode, tdata operator + rates
//  rsp     | out | rsp_tvalid/tready    | tdata level, tuser attack flag
//
//  Each beat first reads the operator row from the store, then updates the
//  row and loads the result register.
//  A new beat is taken while the previous result still waits in rsp.
//  A stalled rsp holds the update step until the result register drains.
//  Synchronous reset clears the row valid bits; rows read as zero until written.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [5:0] operator_index, [10:6] attack_shift, [15:11] decay_shift,
   // [20:16] release_shift, [52:21] sustain_value, [55:53] zero
   input  logic [adsr_env_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [1:0]                              req_tuser,  // [1:0] opcode
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [adsr_env_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // [31:0] envelope_level
   output logic                                    rsp_tuser   // [0] in_attack
);
   import adsr_env_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   adsr_env_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   adsr_env_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   a_one_beat_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a beat is in work");

   a_commit_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed beat did not reach the result register");

   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

endmodule

/* sim/adsr_envelope_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope checker
// Watches the req and rsp streams and keeps its own copy of every operator
// envelope. Each accepted req beat yields one expected rsp beat, and the rsp
// beats are compared in order against those expectations.
// ----------------------------------------------------------------------------
module adsr_envelope_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   // [5:0] operator_index, [10:6] attack_shift, [15:11] decay_shift,
   // [20:16] release_shift, [52:21] sustain_value, [55:53] zero
   input  logic [adsr_env_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [1:0]                              req_tuser,  // [1:0] opcode
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [adsr_env_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,  // [31:0] envelope_level
   input  logic                                    rsp_tuser,  // [0] in_attack
   output int unsigned                             mismatch_count,
   output int unsigned                             outstanding
);

   import adsr_env_pkg::*;

   typedef struct packed {
      logic [REQ_TDATA_BITS-REQ_FIELD_BITS-1:0] pad;
      logic [SUSTAIN_BITS-1:0]                  sustain;
      logic [SHIFT_BITS-1:0]                    release_shift;
      logic [SHIFT_BITS-1:0]                    decay_shift;
      logic [SHIFT_BITS-1:0]                    attack_shift;
      logic [OP_IDX_BITS-1:0]                   op_index;
   } req_beat_type;

   typedef struct packed {
      logic [RSP_TDATA_BITS-1:0] level;
      logic                      attack;
   } envelope_out_type;

   // shadow copy of the operator rows
   logic [LEVEL_BITS-1:0] level_mem   [NUM_OPERATORS];
   logic [SHIFT_BITS-1:0] shift_mem   [NUM_OPERATORS];
   logic                  attack_mem  [NUM_OPERATORS];
   logic [LEVEL_BITS-1:0] bias_mem    [NUM_OPERATORS];
   logic [RATE_BITS-1:0]  rate_mem    [NUM_OPERATORS];  // release, decay, attack from msb
   logic [LEVEL_BITS-1:0] sustain_mem [NUM_OPERATORS];

   envelope_out_type level_queue[$];
   envelope_out_type want;

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] got_val);
      $display("%0t checker: %s expected %h got %h", $realtime, what, exp_val, got_val);
      mismatch_count = mismatch_count + 1;
   endtask

   function automatic envelope_out_type envelope_step(input opcode_type op,
                                                      input req_beat_type beat);
      envelope_out_type      res;
      logic [LEVEL_BITS-1:0] prev;
      logic [LEVEL_BITS-1:0] decayed;
      int unsigned           n;
      res = '0;
      if (beat.op_index >= NUM_OPERATORS)
         return res;
      n = 32'(beat.op_index);
      case (op)
         OP_TICK: begin
            prev         = level_mem[n];
            decayed      = prev - (prev >> shift_mem[n]);
            level_mem[n] = decayed;
            if (attack_mem[n]) begin
               // attack is done once the inverted level drops below 256
               if ((decayed >> ATTACK_END_BITS) == 0) begin
                  attack_mem[n] = 1'b0;
                  bias_mem[n]   = sustain_mem[n];
                  level_mem[n]  = ~sustain_mem[n];
                  shift_mem[n]  = rate_mem[n][2*SHIFT_BITS-1:SHIFT_BITS];
               end
               res.level = ~prev;
            end else begin
               res.level = prev + bias_mem[n];
            end
         end
         OP_KEY_ON: begin
            if (!attack_mem[n]) begin
               attack_mem[n] = 1'b1;
               level_mem[n]  = ~(level_mem[n] + bias_mem[n]);
               shift_mem[n]  = rate_mem[n][SHIFT_BITS-1:0];
            end
         end
         OP_KEY_OFF: begin
            if (attack_mem[n]) begin
               level_mem[n]  = ~level_mem[n];
               attack_mem[n] = 1'b0;
            end else begin
               level_mem[n] = level_mem[n] + bias_mem[n];
               bias_mem[n]  = '0;
            end
            shift_mem[n] = rate_mem[n][3*SHIFT_BITS-1:2*SHIFT_BITS];
         end
         default: begin
            rate_mem[n]    = {beat.release_shift, beat.decay_shift, beat.attack_shift};
            sustain_mem[n] = beat.sustain[LEVEL_BITS-1:0];
         end
      endcase
      res.attack = attack_mem[n];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OPERATORS; i++) begin
            level_mem[i]   = '0;
            shift_mem[i]   = '0;
            attack_mem[i]  = 1'b0;
            bias_mem[i]    = '0;
            rate_mem[i]    = '0;
            sustain_mem[i] = '0;
         end
         level_queue.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (level_queue.size() == 0) begin
               report_mismatch("rsp beat with nothing expected", '0, rsp_tdata);
            end else begin
               want = level_queue.pop_front();
               if (rsp_tdata !== want.level)
                  report_mismatch("envelope_level", want.level, rsp_tdata);
               if (rsp_tuser !== want.attack)
                  report_mismatch("in_attack", 32'(want.attack), 32'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready)
            level_queue.push_back(envelope_step(opcode_type'(req_tuser),
                                                req_beat_type'(req_tdata)));
      end
      outstanding = level_queue.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Directed key on/off/load/tick beats, then random note sequences with noise
// under three idle profiles and a long rsp stall. Checking is done by the
// envelope checker instantiated beside the core.
// ----------------------------------------------------------------------------
module tb;

   import adsr_env_pkg::*;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned send_idle_pct  = 0;
   int unsigned reply_idle_pct = 0;
   int unsigned stall_left     = 0;
   int unsigned beats_sent     = 0;

   always #2 clock = ~clock;

   adsr_envelope_generator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   adsr_envelope_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // rsp side: random stalls, or a counted hold-off when stall_left is loaded
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= reply_idle_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send(input opcode_type op, input logic [OP_IDX_BITS-1:0] idx,
                       input logic [SHIFT_BITS-1:0] atk, input logic [SHIFT_BITS-1:0] dec,
                       input logic [SHIFT_BITS-1:0] rel, input logic [31:0] sus);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_BITS-REQ_FIELD_BITS){1'b0}}, sus, rel, dec, atk, idx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent = beats_sent + 1;
      @(negedge clock);
   endtask

   // unused fields carry random content
   task automatic send_plain(input opcode_type op, input logic [OP_IDX_BITS-1:0] idx);
      send(op, idx, 5'($urandom), 5'($urandom), 5'($urandom), $urandom);
   endtask

   // small shifts keep attack and decay short enough to reach the phase changes
   function automatic logic [SHIFT_BITS-1:0] pick_shift();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return '0;
      else if (roll < 70)
         return 5'd1;
      return 5'($urandom_range(0, 31));
   endfunction

   task automatic play_note();
      logic [OP_IDX_BITS-1:0] n;
      n = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 5)) : 6'($urandom_range(0, 35));
      if ($urandom_range(0, 1))
         send(OP_LOAD, n, pick_shift(), pick_shift(), pick_shift(), $urandom);
      send_plain(OP_KEY_ON, n);
      repeat ($urandom_range(1, 30))
         send_plain(OP_TICK, n);
      send_plain(OP_KEY_OFF, n);
      repeat ($urandom_range(0, 4))
         send_plain(OP_TICK, n);
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned target;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if ($urandom_range(0, 99) < 20)
            send_plain(opcode_type'(2'($urandom_range(0, 3))), 6'($urandom_range(0, 63)));
         else
            play_note();
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(OP_TICK,    0,  0,  0,  0,  32'h0);          // untouched row
      send(OP_LOAD,    0,  1,  2,  31, 32'hFFFF_FFFF);
      send(OP_KEY_ON,  0,  0,  0,  0,  32'h0);
      send(OP_KEY_ON,  0,  0,  0,  0,  32'h0);          // already in attack
      repeat (3) send(OP_TICK, 0, 0, 0, 0, 32'h0);
      send(OP_KEY_OFF, 0,  0,  0,  0,  32'h0);          // release out of attack
      send(OP_TICK,    0,  0,  0,  0,  32'h0);
      send(OP_KEY_OFF, 0,  0,  0,  0,  32'h0);          // bias folded into level
      send(OP_LOAD,    1,  0,  0,  0,  32'h1234_5678);
      send(OP_KEY_ON,  1,  0,  0,  0,  32'h0);
      send(OP_TICK,    1,  0,  0,  0,  32'h0);          // shift 0 ends attack at once
      send(OP_TICK,    1,  0,  0,  0,  32'h0);
      send(OP_LOAD,    35, 31, 31, 31, 32'h0);
      send(OP_KEY_ON,  35, 0,  0,  0,  32'h0);
      send(OP_TICK,    35, 0,  0,  0,  32'h0);
      send(OP_TICK,    36, 0,  0,  0,  32'h0);          // out of range operators
      send(OP_LOAD,    63, 31, 31, 31, 32'hFFFF_FFFF);
      send(OP_KEY_ON,  63, 0,  0,  0,  32'h0);
      send(OP_KEY_OFF, 40, 0,  0,  0,  32'h0);
      drain_results();

      send_idle_pct  = 10;
      reply_idle_pct = 48;
      run_phase(380);
      drain_results();

      send_idle_pct  = 48;
      reply_idle_pct = 10;
      run_phase(380);
      drain_results();

      // no idling, but rsp holds off long enough to back the core up
      send_idle_pct  = 0;
      reply_idle_pct = 0;
      stall_left     = 300;
      run_phase(390);
      drain_results();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
